FILE: rtl/otgs_pkg.sv
package otgs_pkg;

    // field widths fixed by the word layout
    localparam int ADC_BITS   = 12;
    localparam int POS_BITS   = 16;
    localparam int MODE_W     = 3;
    localparam int LED_W      = 10;
    localparam int TRACK_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // default table depth
    localparam int MAX_TRACKS_DEF = 32;

    // carriage modes
    localparam logic [MODE_W-1:0] MODE_HOME       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GOTO_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PLAY       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PAUSE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SKIP_REV   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_END_POS   = 3'd4;

    // configuration reset values
    localparam logic [11:0] RST_SENSOR_TARGET    = 12'd100;
    localparam logic [15:0] RST_CURRENT_GAIN     = 16'd655;
    localparam logic [11:0] RST_DETECT_THRESHOLD = 12'd50;
    localparam logic [11:0] RST_TRACK_THRESHOLD  = 12'd200;
    localparam logic [15:0] RST_RECORD_END_POS   = 16'd13824;

    // led current, Q5.8 mA
    localparam logic [12:0] CUR_MIN      = 13'd1280;
    localparam logic [12:0] CUR_MAX      = 13'd7680;
    localparam logic [12:0] CUR_RESET    = 13'd2560;
    localparam logic [8:0]  CUR_STEP_MAX = 9'd256;
    localparam logic [13:0] CUR_OFFSET   = 14'd2560;

    // pwm: drive = floor((2560 + current) * PWM_MAX / 8448)
    // the /8448 is >>8 then *ceil(2^26/33) >>26, exact over the range
    localparam logic [LED_W-1:0] PWM_MAX   = 10'd1023;
    localparam logic [20:0]      PWM_RECIP = 21'd2033602;

    // presence filter, Q0.16; /10 as *52429 >>19, exact below 81920
    localparam logic [16:0] FILT_ONE   = 17'h10000;
    localparam logic [15:0] FILT_HALF  = 16'h8000;
    localparam logic [15:0] FILT_RECIP = 16'd52429;

    // minimum gap spacing, 2 mm in Q8.8
    localparam logic [15:0] GAP_MIN = 16'd512;

    typedef struct packed {
        logic [ADC_BITS-1:0] sample;
        logic [MODE_W-1:0]   mode;
        logic [POS_BITS-1:0] sensor_position;
        logic [POS_BITS-1:0] arm_position;
    } t_in_word;

    typedef struct packed {
        logic [LED_W-1:0]   led_drive;
        logic               record_present;
        logic               record_removed;
        logic [TRACK_W-1:0] current_track;
        logic [TRACK_W-1:0] track_count;
        logic               track_changed;
    } t_out_word;

endpackage

FILE: rtl/otgs_cell.sv
module otgs_cell #(
    parameter int MAX_TRACKS = otgs_pkg::MAX_TRACKS_DEF,
    parameter int IDX        = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // count wave from the lower neighbor
    input  logic                                  i_tok,
    input  logic [$clog2(MAX_TRACKS+1)-1:0]       i_cnt,
    output logic                                  o_tok,
    output logic [$clog2(MAX_TRACKS+1)-1:0]       o_cnt,
    // broadcast table write
    input  logic                                  i_wr_en,
    input  logic [$clog2(MAX_TRACKS)-1:0]         i_wr_idx,
    input  logic [otgs_pkg::POS_BITS-1:0]         i_wr_pos,
    // broadcast lookup operands
    input  logic [otgs_pkg::POS_BITS-1:0]         i_arm_pos,
    input  logic [$clog2(MAX_TRACKS+1)-1:0]       i_stored
);
    import otgs_pkg::*;

    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam int IDX_W = $clog2(MAX_TRACKS);

    logic [POS_BITS-1:0] r_entry;
    logic                r_tok;
    logic [CNT_W-1:0]    r_cnt;
    logic                hit;

    // entry counts when it is live and the arm sits at or before it
    assign hit = (CNT_W'(IDX) < i_stored) && (i_arm_pos <= r_entry);

    // table entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == IDX_W'(IDX))) begin
            r_entry <= i_wr_pos;
        end
    end

    // wave stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= i_cnt + CNT_W'(hit);
    end

    assign o_tok = r_tok;
    assign o_cnt = r_cnt;

endmodule

FILE: rtl/optical_track_gap_scanner.sv
// Optical track-gap scanner: one word in, one word out. Each tick word moves
// through an input latch, a multiply stage, an apply stage that updates the
// led current, presence filter and gap table, and then a count wave that
// walks the row of MAX_TRACKS table cells, one cell per cycle, to find the
// track under the arm; a home-mode tick skips the wave. A new word is taken
// only once the current tick has passed its result on. The result sits in
// an output register, so the next word is taken while a finished result
// still waits. The table holds sorted gap positions; the led drive is zero
// in the dark phase and in home mode.
module optical_track_gap_scanner #(
    parameter int MAX_TRACKS = otgs_pkg::MAX_TRACKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick words in
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  otgs_pkg::t_in_word                  i_in_word,
    // result words out
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output otgs_pkg::t_out_word                 o_out_word,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [otgs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [otgs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import otgs_pkg::*;

    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam int IDX_W = $clog2(MAX_TRACKS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_APPLY  = 5'b00100,
        S_SCAN   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [11:0] r_sensor_target;
    logic [15:0] r_current_gain;
    logic [11:0] r_detect_thr;
    logic [11:0] r_track_thr;
    logic [15:0] r_record_end;

    // scanner state
    logic [ADC_BITS-1:0]  r_prev_sample;
    logic signed [12:0]   r_prev_value;
    logic [12:0]          r_led_current;
    logic [15:0]          r_filter;
    logic                 r_dark;
    logic                 r_gap_armed;
    logic [CNT_W-1:0]     r_stored;
    logic [POS_BITS-1:0]  r_last_gap;
    logic [CNT_W-1:0]     r_last_ann;

    // per-tick work registers
    t_in_word             r_in;
    logic                 r_home;
    logic [11:0]          r_swing;
    logic                 r_err_neg;
    logic [27:0]          r_mag_prod;
    logic                 r_filt_up;
    logic [32:0]          r_filt_prod;
    logic [23:0]          r_pwm_n;
    logic [LED_W-1:0]     r_led;
    logic                 r_was_dark;
    logic                 r_present;
    logic                 r_removed;
    logic [CNT_W-1:0]     r_track;
    logic                 r_changed;
    logic                 r_start;

    // output register
    logic                 r_out_valid;
    t_out_word            r_out;

    // handshake helpers
    logic in_take, out_free;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // multiply stage operands
    logic [12:0] swing_d;
    logic [11:0] swing;
    logic [12:0] err_s;
    logic [11:0] err_abs;
    logic        filt_up;
    logic [16:0] filt_x;

    assign swing_d = {1'b0, r_in.sample} - {1'b0, r_prev_sample};
    assign swing   = swing_d[12] ? 12'(13'd0 - swing_d) : swing_d[11:0];
    assign err_s   = {1'b0, r_sensor_target} - {1'b0, swing};
    assign err_abs = err_s[12] ? 12'(13'd0 - err_s) : err_s[11:0];
    assign filt_up = swing > r_detect_thr;
    assign filt_x  = filt_up ? (FILT_ONE - {1'b0, r_filter}) : {1'b0, r_filter};

    // apply stage: presence filter
    logic [13:0] filt_q;
    logic [15:0] n_filter;
    logic        present_new;

    assign filt_q      = r_filt_prod[32:19];
    assign n_filter    = r_filt_up ? (r_filter + 16'(filt_q)) : (r_filter - 16'(filt_q));
    assign present_new = n_filter > FILT_HALF;

    // apply stage: led current regulation
    logic [19:0] mag;
    logic [8:0]  step;
    logic [13:0] cur_sum;
    logic [12:0] n_led_current;

    assign mag     = r_mag_prod[27:8];
    assign step    = (mag > 20'(CUR_STEP_MAX)) ? CUR_STEP_MAX : mag[8:0];
    assign cur_sum = r_err_neg ? ({1'b0, r_led_current} - {5'b0, step})
                               : ({1'b0, r_led_current} + {5'b0, step});

    always_comb begin
        priority if (cur_sum < 14'(CUR_MIN)) begin
            n_led_current = CUR_MIN;
        end else if (cur_sum > 14'(CUR_MAX)) begin
            n_led_current = CUR_MAX;
        end else begin
            n_led_current = cur_sum[12:0];
        end
    end

    // apply stage: led pwm
    logic [36:0] pwm_prod;
    logic [10:0] pwm_q;

    assign pwm_prod = r_pwm_n[23:8] * PWM_RECIP;
    assign pwm_q    = pwm_prod[36:26];

    // apply stage: gap detection with hysteresis
    logic signed [12:0] value;
    logic signed [13:0] diff;
    logic signed [14:0] neg_diff;
    logic signed [15:0] neg_diff_x2;
    logic               disarm, arm;
    logic               in_window;
    logic signed [16:0] gap_dist;
    logic               gap_room;
    logic               armed_mid;
    logic               n_gap_armed;
    logic               gap_write;

    assign value       = $signed({1'b0, r_swing}) - $signed({1'b0, r_sensor_target});
    assign diff        = $signed({value[12], value}) - $signed({r_prev_value[12], r_prev_value});
    assign neg_diff    = $signed(15'd0) - $signed({diff[13], diff});
    assign neg_diff_x2 = $signed({neg_diff, 1'b0});
    assign disarm      = neg_diff_x2 < $signed({4'b0, r_track_thr});
    assign arm         = neg_diff > $signed({3'b0, r_track_thr});
    assign in_window   = {1'b0, r_in.sensor_position} >=
                         ({1'b0, r_record_end} + {1'b0, GAP_MIN});
    assign gap_dist    = $signed({1'b0, r_in.sensor_position}) - $signed({1'b0, r_last_gap});
    assign gap_room    = (r_stored < CNT_W'(MAX_TRACKS)) &&
                         ((r_stored == '0) || (gap_dist >= $signed({1'b0, GAP_MIN})));

    always_comb begin
        n_gap_armed = r_gap_armed;
        gap_write   = 1'b0;
        if (r_dark && (r_in.mode == MODE_GOTO_START) && in_window) begin
            armed_mid = (disarm && r_gap_armed) ? 1'b0 : r_gap_armed;
            n_gap_armed = armed_mid;
            if (arm && !armed_mid) begin
                n_gap_armed = 1'b1;
                gap_write   = gap_room;
            end
        end else begin
            armed_mid = r_gap_armed;
        end
    end

    logic wr_en;

    assign wr_en = (r_state == S_APPLY) && !r_home && gap_write;

    // cell row: count wave carries the number of entries at or past the arm
    logic             link_tok [0:MAX_TRACKS];
    logic [CNT_W-1:0] link_cnt [0:MAX_TRACKS];

    assign link_tok[0] = r_start;
    assign link_cnt[0] = '0;

    for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
        otgs_cell #(
            .MAX_TRACKS (MAX_TRACKS),
            .IDX        (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (link_tok[g]),
            .i_cnt     (link_cnt[g]),
            .o_tok     (link_tok[g+1]),
            .o_cnt     (link_cnt[g+1]),
            .i_wr_en   (wr_en),
            .i_wr_idx  (r_stored[IDX_W-1:0]),
            .i_wr_pos  (r_in.sensor_position),
            .i_arm_pos (r_in.arm_position),
            .i_stored  (r_stored)
        );
    end

    // track under the arm from the wave count
    logic             scan_done;
    logic [CNT_W:0]   cnt_p1;
    logic [CNT_W-1:0] track;
    logic             play_mode;
    logic             n_changed;

    assign scan_done = (r_state == S_SCAN) && link_tok[MAX_TRACKS];
    assign cnt_p1    = {1'b0, link_cnt[MAX_TRACKS]} + (CNT_W+1)'(1);
    assign track     = (r_stored == '0) ? '0 :
                       ((cnt_p1 > {1'b0, r_stored}) ? r_stored : cnt_p1[CNT_W-1:0]);
    assign play_mode = (r_in.mode >= MODE_PLAY) && (r_in.mode <= MODE_SKIP_REV);
    assign n_changed = play_mode && (track != '0) && (track != r_last_ann);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state = r_home ? S_RESULT : S_SCAN;
            end
            S_SCAN: begin
                if (link_tok[MAX_TRACKS]) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= (r_state == S_APPLY) && !r_home;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_target <= RST_SENSOR_TARGET;
            r_current_gain  <= RST_CURRENT_GAIN;
            r_detect_thr    <= RST_DETECT_THRESHOLD;
            r_track_thr     <= RST_TRACK_THRESHOLD;
            r_record_end    <= RST_RECORD_END_POS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SENSOR_TARGET:    r_sensor_target <= i_cfg_data[11:0];
                CFG_CURRENT_GAIN:     r_current_gain  <= i_cfg_data;
                CFG_DETECT_THRESHOLD: r_detect_thr    <= i_cfg_data[11:0];
                CFG_TRACK_THRESHOLD:  r_track_thr     <= i_cfg_data[11:0];
                CFG_RECORD_END_POS:   r_record_end    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // scanner state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sample <= '0;
            r_prev_value  <= '0;
            r_led_current <= CUR_RESET;
            r_filter      <= '0;
            r_dark        <= 1'b0;
            r_gap_armed   <= 1'b0;
            r_stored      <= '0;
            r_last_ann    <= '0;
        end else begin
            if ((r_state == S_MUL) && !r_home) begin
                r_prev_sample <= r_in.sample;
            end
            if (r_state == S_APPLY) begin
                if (r_home) begin
                    r_stored   <= '0;
                    r_last_ann <= '0;
                end else begin
                    r_filter <= n_filter;
                    r_dark   <= !r_dark;
                    if (r_dark) begin
                        r_led_current <= n_led_current;
                        r_prev_value  <= value;
                        r_gap_armed   <= n_gap_armed;
                    end
                    if (wr_en) begin
                        r_stored <= r_stored + CNT_W'(1);
                    end
                end
            end
            if (scan_done && n_changed) begin
                r_last_ann <= track;
            end
        end
    end

    // last stored gap, for the spacing test
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_last_gap <= r_in.sensor_position;
        end
    end

    // per-tick datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in   <= i_in_word;
            r_home <= (i_in_word.mode == MODE_HOME);
        end
        if (r_state == S_MUL) begin
            r_swing     <= swing;
            r_err_neg   <= err_s[12];
            r_mag_prod  <= err_abs * r_current_gain;
            r_filt_up   <= filt_up;
            r_filt_prod <= filt_x * FILT_RECIP;
            r_pwm_n     <= ({1'b0, r_led_current} + CUR_OFFSET) * PWM_MAX;
        end
        if (r_state == S_APPLY) begin
            r_led      <= (pwm_q > 11'(PWM_MAX)) ? PWM_MAX : pwm_q[LED_W-1:0];
            r_was_dark <= r_dark;
            r_present  <= r_home ? (r_filter > FILT_HALF) : present_new;
            r_removed  <= !r_home && !present_new &&
                          ((r_in.mode == MODE_PLAY) || (r_in.mode == MODE_PAUSE));
            r_track    <= '0;
            r_changed  <= 1'b0;
        end
        if (scan_done) begin
            r_track   <= track;
            r_changed <= n_changed;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_RESULT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESULT) && out_free) begin
            r_out.led_drive      <= (r_home || r_was_dark) ? '0 : r_led;
            r_out.record_present <= r_present;
            r_out.record_removed <= r_removed;
            r_out.current_track  <= TRACK_W'(r_track);
            r_out.track_count    <= TRACK_W'(r_stored);
            r_out.track_changed  <= r_changed;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: tb/optical_track_gap_scanner_tb.sv
module optical_track_gap_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import otgs_pkg::*;

    // modes that the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_SKIP_FWD = 3'd4;
    localparam logic [MODE_W-1:0] MODE_OTHER    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 3'd7;

    localparam int TABLE_DEPTH = MAX_TRACKS_DEF;
    localparam int SETTLE_CYC  = 50;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_LEN    = 500;
    localparam int PHASE_TICKS = 350;

    // clock and reset
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // block ports
    logic                  tick_valid = 1'b0;
    logic                  dut_in_stall;
    t_in_word              tick_word  = '0;
    logic                  rslt_valid;
    logic                  rslt_stall = 1'b0;
    t_out_word             rslt_word;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    optical_track_gap_scanner i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tick_valid),
        .o_in_stall  (dut_in_stall),
        .i_in_word   (tick_word),
        .o_out_valid (rslt_valid),
        .i_out_stall (rslt_stall),
        .o_out_word  (rslt_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // register copies
    int cfg_target = int'(RST_SENSOR_TARGET);
    int cfg_gain   = int'(RST_CURRENT_GAIN);
    int cfg_detect = int'(RST_DETECT_THRESHOLD);
    int cfg_gapthr = int'(RST_TRACK_THRESHOLD);
    int cfg_end    = int'(RST_RECORD_END_POS);

    // scanner state copy
    int last_sample     = 0;
    int last_level      = 0;
    int led_ma_q8       = int'(CUR_RESET);
    int presence_acc    = 0;
    bit dark_now        = 1'b0;
    bit gap_latched     = 1'b0;
    int gap_count       = 0;
    int gap_pos [TABLE_DEPTH];
    int announced_track = 0;

    // words waiting to be sent and results waiting to arrive
    t_in_word  tick_queue [$];
    t_out_word rslt_expect [$];

    int  ticks_queued  = 0;
    int  ticks_sent    = 0;
    int  rslt_seen     = 0;
    int  mismatches    = 0;
    int  most_tracks   = 0;
    int  removed_seen  = 0;
    int  changed_seen  = 0;
    int  send_gap      = 0;
    int  recv_gap      = 0;
    bit  send_quiet    = 1'b0;
    bit  recv_quiet    = 1'b0;
    bit  hold_on       = 1'b0;
    bit  hold_used     = 1'b0;
    int  hold_left     = 0;

    // expected result of one tick, advances the state copy
    function automatic t_out_word predict_tick(t_in_word w);
        t_out_word r;
        int  swing, level, err, step, slope, v, pos, apos, t, trk;
        bit  present;
        longint mag, pwm;
        r = '0;
        if (w.mode == MODE_HOME) begin
            gap_count       = 0;
            announced_track = 0;
            r.record_present = presence_acc > int'(FILT_HALF);
            return r;
        end
        swing = int'(w.sample) - last_sample;
        if (swing < 0) swing = -swing;
        last_sample = int'(w.sample);
        level = swing - cfg_target;
        pos   = int'(w.sensor_position);
        apos  = int'(w.arm_position);

        // presence low-pass
        if (swing > cfg_detect) presence_acc += (65536 - presence_acc) / 10;
        else                    presence_acc -= presence_acc / 10;
        present = presence_acc > int'(FILT_HALF);
        r.record_present = present;
        r.record_removed = !present && (w.mode == MODE_PLAY || w.mode == MODE_PAUSE);

        if (dark_now) begin
            // current regulation toward the target swing
            err = cfg_target - swing;
            mag = (longint'(err < 0 ? -err : err) * longint'(cfg_gain)) >>> 8;
            if (mag > longint'(CUR_STEP_MAX)) mag = longint'(CUR_STEP_MAX);
            step = int'(mag);
            led_ma_q8 += (err < 0) ? -step : step;
            if (led_ma_q8 < int'(CUR_MIN)) led_ma_q8 = int'(CUR_MIN);
            if (led_ma_q8 > int'(CUR_MAX)) led_ma_q8 = int'(CUR_MAX);

            // gap scan with hysteresis
            slope = level - last_level;
            last_level = level;
            if (w.mode == MODE_GOTO_START && pos >= cfg_end + int'(GAP_MIN)) begin
                v = -slope;
                if (2 * v < cfg_gapthr && gap_latched) gap_latched = 1'b0;
                if (v > cfg_gapthr && !gap_latched) begin
                    gap_latched = 1'b1;
                    if (gap_count < TABLE_DEPTH &&
                        (gap_count == 0 || pos - gap_pos[gap_count-1] >= int'(GAP_MIN))) begin
                        gap_pos[gap_count] = pos;
                        gap_count++;
                    end
                end
            end
        end else begin
            pwm = (longint'(int'(CUR_OFFSET) + led_ma_q8) * longint'(PWM_MAX)) / 8448;
            if (pwm > longint'(PWM_MAX)) pwm = longint'(PWM_MAX);
            r.led_drive = pwm[LED_W-1:0];
        end
        dark_now = !dark_now;

        // track under the arm, walking down from the last entry
        if (gap_count == 0) begin
            trk = 0;
        end else begin
            t = gap_count - 1;
            while (t >= 0 && apos <= gap_pos[t]) t--;
            trk = gap_count - t;
            if (trk > gap_count) trk = gap_count;
        end
        if (w.mode >= MODE_PLAY && w.mode <= MODE_SKIP_REV && trk > 0 &&
            trk != announced_track) begin
            announced_track = trk;
            r.track_changed = 1'b1;
        end
        r.current_track = trk[TRACK_W-1:0];
        r.track_count   = gap_count[TRACK_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_tick(int s, logic [MODE_W-1:0] md, int sp, int ap);
        t_in_word w;
        w.sample          = s[ADC_BITS-1:0];
        w.mode            = md;
        w.sensor_position = sp[POS_BITS-1:0];
        w.arm_position    = ap[POS_BITS-1:0];
        tick_queue.push_back(w);
        ticks_queued++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_SENSOR_TARGET:    cfg_target = val & 12'hFFF;
            CFG_CURRENT_GAIN:     cfg_gain   = val & 16'hFFFF;
            CFG_DETECT_THRESHOLD: cfg_detect = val & 12'hFFF;
            CFG_TRACK_THRESHOLD:  cfg_gapthr = val & 12'hFFF;
            CFG_RECORD_END_POS:   cfg_end    = val & 16'hFFFF;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(int tgt, int gain, int det, int thr, int endp);
        cfg_write(CFG_SENSOR_TARGET, tgt);
        cfg_write(CFG_CURRENT_GAIN, gain);
        cfg_write(CFG_DETECT_THRESHOLD, det);
        cfg_write(CFG_TRACK_THRESHOLD, thr);
        cfg_write(CFG_RECORD_END_POS, endp);
    endtask

    // wait until every word is out and every result is back
    task automatic drain();
        while (tick_queue.size() > 0 || tick_valid || rslt_expect.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // random episodes: scans from home, play runs, noise, other modes
    task automatic queue_random(int count);
        int goal, len, pos, apos, hi, lo, s, prev, k, flat;
        logic [MODE_W-1:0] md;
        goal = ticks_queued + count;
        prev = 0;
        while (ticks_queued < goal) begin
            hi = $urandom_range(150, 4095);
            lo = $urandom_range(0, hi - 150);
            case ($urandom_range(0, 9))
                0: begin
                    // raw noise
                    for (k = 0; k < 8; k++)
                        push_tick($urandom_range(0, 4095), $urandom_range(0, 7),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535));
                end
                1, 2, 3, 4: begin
                    // home, then a scan toward the spindle
                    push_tick($urandom_range(0, 4095), MODE_HOME,
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
                    pos = cfg_end + int'(GAP_MIN) + $urandom_range(0, 200);
                    if ($urandom_range(0, 3) == 0) pos -= $urandom_range(0, 600);
                    if (pos < 0) pos = 0;
                    if (pos > 65535) pos = 65535;
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(150, 300)
                                                      : $urandom_range(10, 80);
                    for (k = 0; k < len; k++) begin
                        s = (k % 2) ? hi : lo;
                        if ($urandom_range(0, 5) == 0) s = prev;
                        push_tick(s, MODE_GOTO_START, pos, $urandom_range(0, 65535));
                        prev = s;
                        pos += $urandom_range(0, 400);
                        if (pos > 65535) pos = 65535;
                    end
                end
                5, 6, 7, 8: begin
                    // playing, pausing and skipping over the table
                    len  = $urandom_range(10, 60);
                    md   = $urandom_range(MODE_PLAY, MODE_SKIP_REV);
                    flat = 0;
                    for (k = 0; k < len; k++) begin
                        if ($urandom_range(0, 7) == 0) md = $urandom_range(MODE_PLAY, MODE_SKIP_REV);
                        if (flat == 0 && $urandom_range(0, 15) == 0) flat = $urandom_range(2, 20);
                        if (flat > 0) begin
                            s = prev;
                            flat--;
                        end else begin
                            s = (k % 2) ? hi : lo;
                        end
                        apos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(cfg_end, 65535);
                        push_tick(s, md, $urandom_range(0, 65535), apos);
                        prev = s;
                    end
                end
                default: begin
                    // other modes and scans at random positions
                    for (k = 0; k < 6; k++) begin
                        md = ($urandom_range(0, 1) == 0) ? MODE_GOTO_START
                                                         : $urandom_range(MODE_OTHER, MODE_SPARE);
                        s  = (k % 2) ? hi : lo;
                        push_tick(s, md, $urandom_range(0, 65535), $urandom_range(0, 65535));
                        prev = s;
                    end
                end
            endcase
        end
    endtask

    // driver: offers queued words, draws a gap after each accepted one
    always @(posedge i_clk) begin : drive_tick
        t_in_word nxt_word;
        logic     nxt_valid;
        int       nxt_gap;
        nxt_word  = tick_word;
        nxt_valid = tick_valid;
        nxt_gap   = send_gap;
        if (!rst_n) begin
            nxt_valid = 1'b0;
            nxt_gap   = 0;
        end else begin
            if (tick_valid && !dut_in_stall) begin
                rslt_expect.push_back(predict_tick(tick_word));
                ticks_sent <= ticks_sent + 1;
                nxt_valid = 1'b0;
                nxt_gap   = send_quiet ? 0 : $urandom_range(0, 7);
            end
            if (!nxt_valid) begin
                if (nxt_gap > 0) begin
                    nxt_gap--;
                end else if (tick_queue.size() > 0) begin
                    nxt_word  = tick_queue.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        tick_word  <= nxt_word;
        tick_valid <= nxt_valid;
        send_gap   <= nxt_gap;
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!rst_n) begin
            hold_on   <= 1'b0;
            hold_left <= 0;
        end else if (!hold_used && ticks_sent >= HOLD_AT) begin
            hold_used <= 1'b1;
            hold_on   <= 1'b1;
            hold_left <= HOLD_LEN;
        end else if (hold_on) begin
            if (hold_left <= 1) hold_on <= 1'b0;
            hold_left <= hold_left - 1;
        end
    end

    // monitor: checks each accepted result word against the oldest expectation
    always @(posedge i_clk) begin : watch_result
        t_out_word want;
        int        nxt_gap;
        nxt_gap = (recv_gap > 0) ? recv_gap - 1 : 0;
        if (!rst_n) begin
            nxt_gap = 0;
        end else if (rslt_valid && !rslt_stall) begin
            rslt_seen++;
            if (rslt_expect.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                want = rslt_expect.pop_front();
                check_field("led_drive", want.led_drive, rslt_word.led_drive);
                check_field("record_present", want.record_present, rslt_word.record_present);
                check_field("record_removed", want.record_removed, rslt_word.record_removed);
                check_field("current_track", want.current_track, rslt_word.current_track);
                check_field("track_count", want.track_count, rslt_word.track_count);
                check_field("track_changed", want.track_changed, rslt_word.track_changed);
                if (int'(want.track_count) > most_tracks) most_tracks = want.track_count;
                removed_seen += want.record_removed;
                changed_seen += want.track_changed;
            end
            nxt_gap = recv_quiet ? 0 : $urandom_range(0, 7);
        end
        recv_gap   <= nxt_gap;
        rslt_stall <= rst_n && (hold_on || nxt_gap > 0);
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // phases
    initial begin : run_phases
        int k;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed ticks at reset settings
        @(negedge i_clk);
        push_tick(0, MODE_HOME, 0, 0);
        push_tick(4095, MODE_PLAY, 0, 65535);          // empty table
        push_tick(0, MODE_PAUSE, 65535, 0);
        push_tick(4095, MODE_OTHER, 65535, 65535);
        push_tick(0, MODE_SPARE, 0, 0);                // unused mode code
        // swing drops just below the scan window
        push_tick(3000, MODE_GOTO_START, 14335, 0);
        push_tick(0, MODE_GOTO_START, 14335, 0);
        push_tick(0, MODE_GOTO_START, 14335, 0);
        push_tick(0, MODE_GOTO_START, 14335, 0);
        push_tick(3000, MODE_GOTO_START, 14335, 0);
        push_tick(0, MODE_GOTO_START, 14335, 0);
        // first gap right at the window edge
        push_tick(3000, MODE_GOTO_START, 14336, 0);
        push_tick(0, MODE_GOTO_START, 14336, 0);
        push_tick(0, MODE_GOTO_START, 14336, 0);
        push_tick(0, MODE_GOTO_START, 14336, 0);
        // second drop too close to the first
        push_tick(3000, MODE_GOTO_START, 14847, 0);
        push_tick(0, MODE_GOTO_START, 14847, 0);
        push_tick(0, MODE_GOTO_START, 14847, 0);
        push_tick(0, MODE_GOTO_START, 14847, 0);
        // third drop far enough away
        push_tick(3000, MODE_GOTO_START, 15360, 0);
        push_tick(0, MODE_GOTO_START, 15360, 0);
        push_tick(0, MODE_GOTO_START, 15360, 0);
        push_tick(0, MODE_GOTO_START, 15360, 0);
        // arm before every entry, past every entry, in between
        push_tick(4095, MODE_PLAY, 0, 0);
        push_tick(0, MODE_SKIP_FWD, 0, 65535);
        push_tick(4095, MODE_SKIP_REV, 0, 14500);
        queue_random(PHASE_TICKS - 26);
        drain();

        // low extremes, gain at its top
        set_all(0, 65535, 0, 0, 0);
        @(posedge i_clk);
        send_quiet <= 1'b1;
        @(negedge i_clk);
        queue_random(PHASE_TICKS);
        drain();

        // high extremes, scan window beyond the carriage range
        set_all(4095, 0, 4095, 4095, 65535);
        @(posedge i_clk);
        send_quiet <= 1'b0;
        recv_quiet <= 1'b1;
        @(negedge i_clk);
        queue_random(PHASE_TICKS);
        drain();

        // random mid-range setting
        set_all($urandom_range(0, 1500), $urandom_range(0, 65535), $urandom_range(0, 400),
                $urandom_range(50, 1500), $urandom_range(0, 45000));
        @(posedge i_clk);
        send_quiet <= 1'b1;
        @(negedge i_clk);
        queue_random(PHASE_TICKS);
        drain();

        // back to the reset setting
        set_all(int'(RST_SENSOR_TARGET), int'(RST_CURRENT_GAIN), int'(RST_DETECT_THRESHOLD),
                int'(RST_TRACK_THRESHOLD), int'(RST_RECORD_END_POS));
        @(posedge i_clk);
        send_quiet <= 1'b0;
        recv_quiet <= 1'b0;
        @(negedge i_clk);
        queue_random(PHASE_TICKS);
        drain();

        $display("%0d ticks sent, %0d results checked over 5 register settings",
                 ticks_sent, rslt_seen);
        $display("table peaked at %0d entries, %0d removal flags, %0d track changes",
                 most_tracks, removed_seen, changed_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/otgs_pkg.sv
rtl/otgs_cell.sv
rtl/optical_track_gap_scanner.sv
tb/optical_track_gap_scanner_tb.sv
